FILE: rtl/flmr_pkg.sv
package flmr_pkg;

   localparam int NumRows   = 8;
   localparam int RowWidth  = 8;
   localparam int GlyphCols = 3;
   localparam int GlyphBits = 5;

   typedef logic [7:0]                                char_type;
   typedef logic [RowWidth-1:0]                       row_type;
   typedef logic [GlyphBits-1:0]                      glyph_col_type;
   // index c selects glyph column c; bit 4 of a column is its leading pixel
   typedef logic [GlyphCols-1:0][GlyphBits-1:0]       glyph_type;

   typedef struct packed {
      char_type first_char;
      char_type second_char;
      char_type third_char;
      char_type fourth_char;
      logic     dot_on;
   } frame_type;

   localparam char_type CharPlus   = 8'h2B;
   localparam char_type CharMinus  = 8'h2D;
   localparam char_type CharUpperC = 8'h43;
   localparam char_type CharDigit0 = 8'h30;
   localparam char_type CharDigit1 = 8'h31;
   localparam char_type CharDigit2 = 8'h32;
   localparam char_type CharDigit3 = 8'h33;
   localparam char_type CharDigit4 = 8'h34;
   localparam char_type CharDigit5 = 8'h35;
   localparam char_type CharDigit6 = 8'h36;
   localparam char_type CharDigit7 = 8'h37;
   localparam char_type CharDigit8 = 8'h38;
   localparam char_type CharDigit9 = 8'h39;

   function automatic glyph_type make_glyph(glyph_col_type c0, glyph_col_type c1,
                                            glyph_col_type c2);
      return {c2, c1, c0};
   endfunction

   // 3x5 font; anything not listed draws blank
   function automatic glyph_type glyph_lookup(char_type code);
      glyph_type g;
      case (code)
         CharPlus:   g = make_glyph(5'd4,  5'd14, 5'd4);
         CharMinus:  g = make_glyph(5'd4,  5'd4,  5'd4);
         CharUpperC: g = make_glyph(5'd31, 5'd17, 5'd17);
         CharDigit0: g = make_glyph(5'd31, 5'd17, 5'd31);
         CharDigit1: g = make_glyph(5'd0,  5'd0,  5'd31);
         CharDigit2: g = make_glyph(5'd23, 5'd21, 5'd29);
         CharDigit3: g = make_glyph(5'd17, 5'd21, 5'd31);
         CharDigit4: g = make_glyph(5'd28, 5'd4,  5'd31);
         CharDigit5: g = make_glyph(5'd29, 5'd21, 5'd23);
         CharDigit6: g = make_glyph(5'd31, 5'd21, 5'd23);
         CharDigit7: g = make_glyph(5'd16, 5'd16, 5'd31);
         CharDigit8: g = make_glyph(5'd31, 5'd21, 5'd31);
         CharDigit9: g = make_glyph(5'd29, 5'd21, 5'd31);
         default:    g = '0;
      endcase
      return g;
   endfunction

endpackage

FILE: rtl/flmr_req_if.sv
interface flmr_req_if;
   import flmr_pkg::*;

   logic     valid;
   logic     ready;
   char_type first_char;
   char_type second_char;
   char_type third_char;
   char_type fourth_char;
   logic     dot_on;

   modport source (output valid, output first_char, output second_char,
                   output third_char, output fourth_char, output dot_on,
                   input ready);
   modport sink   (input valid, input first_char, input second_char,
                   input third_char, input fourth_char, input dot_on,
                   output ready);
endinterface

FILE: rtl/flmr_rsp_if.sv
interface flmr_rsp_if;
   import flmr_pkg::*;

   logic    valid;
   logic    ready;
   row_type row_0;
   row_type row_1;
   row_type row_2;
   row_type row_3;
   row_type row_4;
   row_type row_5;
   row_type row_6;
   row_type row_7;

   modport source (output valid, output row_0, output row_1, output row_2, output row_3,
                   output row_4, output row_5, output row_6, output row_7,
                   input ready);
   modport sink   (input valid, input row_0, input row_1, input row_2, input row_3,
                   input row_4, input row_5, input row_6, input row_7,
                   output ready);
endinterface

FILE: rtl/four_glyph_led_matrix_renderer_unit.sv
// An accepted req_ transaction is held in the input register; the result register then takes the
// font lookup and pixel placement and drives rsp_valid.
// Throughput: one frame per cycle while rsp_ready holds high; the two register stages move together when the
// result side takes its transaction, so rsp_ready may stall without bubbles.
// Reset: synchronous, active high; clears both stage valids, data is not reset.
module four_glyph_led_matrix_renderer_unit (
   input  logic              clock,
   input  logic              reset,
   flmr_req_if.sink          req_if,
   flmr_rsp_if.source        rsp_if
);
   import flmr_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   frame_type s1_frame_ff, s1_frame_in;
   logic      s2_valid_ff, s2_valid_in;
   row_type   rows_ff [NumRows];
   row_type   rows_in [NumRows];
   row_type   rows_calc [NumRows];

   logic      s1_ready, s2_ready, s1_load, s2_load;
   glyph_type g0, g1, g2, g3;

   assign s2_ready = !s2_valid_ff || rsp_if.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s1_load  = req_if.valid && s1_ready;
   assign s2_load  = s1_valid_ff && s2_ready;

   assign req_if.ready = s1_ready;

   assign s1_valid_in = s1_ready ? req_if.valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff  : s2_valid_ff;

   always_comb begin
      s1_frame_in = s1_frame_ff;
      if (s1_load) begin
         s1_frame_in.first_char  = req_if.first_char;
         s1_frame_in.second_char = req_if.second_char;
         s1_frame_in.third_char  = req_if.third_char;
         s1_frame_in.fourth_char = req_if.fourth_char;
         s1_frame_in.dot_on      = req_if.dot_on;
      end
   end

   assign g0 = glyph_lookup(s1_frame_ff.first_char);
   assign g1 = glyph_lookup(s1_frame_ff.second_char);
   assign g2 = glyph_lookup(s1_frame_ff.third_char);
   assign g3 = glyph_lookup(s1_frame_ff.fourth_char);

   always_comb begin
      for (int r = 0; r < NumRows; r++) begin
         rows_calc[r] = '0;
      end
      for (int c = 0; c < GlyphCols; c++) begin
         // top left, upright: row r shows glyph bit 4-r
         for (int r = 0; r < GlyphBits; r++) begin
            rows_calc[r][7-c] = rows_calc[r][7-c] | g0[c][4-r];
         end
         // bottom right, flipped: rows 3..7 show glyph bit 7-r
         for (int r = 3; r < NumRows; r++) begin
            rows_calc[r][2-c] = rows_calc[r][2-c] | g2[c][7-r];
         end
         // top right, turned
         rows_calc[2-c][4:0] = rows_calc[2-c][4:0] | g1[c];
         // bottom, lying
         rows_calc[7-c][7:3] = rows_calc[7-c][7:3] | g3[c];
      end
      rows_calc[3][4] = rows_calc[3][4] | s1_frame_ff.dot_on;
   end

   always_comb begin
      for (int r = 0; r < NumRows; r++) begin
         rows_in[r] = s2_load ? rows_calc[r] : rows_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_frame_ff <= s1_frame_in;
      rows_ff     <= rows_in;
   end

   assign rsp_if.valid = s2_valid_ff;
   assign rsp_if.row_0 = rows_ff[0];
   assign rsp_if.row_1 = rows_ff[1];
   assign rsp_if.row_2 = rows_ff[2];
   assign rsp_if.row_3 = rows_ff[3];
   assign rsp_if.row_4 = rows_ff[4];
   assign rsp_if.row_5 = rows_ff[5];
   assign rsp_if.row_6 = rows_ff[6];
   assign rsp_if.row_7 = rows_ff[7];

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> s1_valid_ff)
      else $error("accepted transaction lost at input stage");

   a_centre_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (!rsp_if.row_3[3] && !rsp_if.row_4[4] && !rsp_if.row_4[3]))
      else $error("centre pixel lit that no glyph covers");

   a_dot_carried: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (rows_ff[3][4] == $past(s1_frame_ff.dot_on)))
      else $error("dot flag not carried to row 3");

endmodule
